// ===== hdl/mlptw_pkg.sv =====
// ----------------------------------------------------------------------------
// mlptw_pkg
// Shared constants, codes and types for the page table walker.
// ----------------------------------------------------------------------------
`default_nettype none

package mlptw_pkg;

  localparam int PAGE_BITS  = 12;
  localparam int LEVELS     = 4;
  localparam int FRAME_POOL = 64;

  localparam int IDX_BITS    = PAGE_BITS - 3;
  localparam int FRAME_W     = (FRAME_POOL > 1) ? $clog2(FRAME_POOL) : 1;
  localparam int NFREE_W     = $clog2(FRAME_POOL + 1);
  localparam int ENT_W       = FRAME_W + 1;
  localparam int ADDR_W      = FRAME_W + IDX_BITS;
  localparam int STORE_DEPTH = FRAME_POOL * (2 ** IDX_BITS);
  localparam int VPN_W       = LEVELS * IDX_BITS;
  localparam int LVL_W       = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int VA_W        = 48;
  localparam int PA_W        = 18;
  localparam int STATUS_W    = 2;

  localparam logic OP_TRANSLATE = 1'b0;
  localparam logic OP_ALLOCATE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNMAPPED   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_POOL_EMPTY = 2'd2;

  typedef logic [FRAME_W-1:0] frame_t;
  typedef logic [ADDR_W-1:0]  tbl_addr_t;

  // table entry: frame number above, valid in bit 0
  typedef struct packed {
    frame_t frame;
    logic   valid;
  } tbl_entry_t;

  typedef struct packed {
    logic       we;
    tbl_addr_t  addr;
    tbl_entry_t wdata;
  } tbl_req_t;

endpackage

`default_nettype wire

// ===== hdl/mlptw_in_if.sv =====
// ----------------------------------------------------------------------------
// mlptw_in_if
// Request channel: operation and virtual address with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface mlptw_in_if
  import mlptw_pkg::*;
;
  logic            valid;
  logic            ready;
  logic            operation;
  logic [VA_W-1:0] virt_addr;

  modport source (output valid, output operation, output virt_addr, input ready);
  modport sink   (input valid, input operation, input virt_addr, output ready);
endinterface

`default_nettype wire

// ===== hdl/mlptw_out_if.sv =====
// ----------------------------------------------------------------------------
// mlptw_out_if
// Result channel: physical address and status with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface mlptw_out_if
  import mlptw_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [PA_W-1:0]     phys_addr;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output phys_addr, output status, input ready);
  modport sink   (input valid, input phys_addr, input status, output ready);
endinterface

`default_nettype wire

// ===== hdl/mlptw_table_ram.sv =====
// ----------------------------------------------------------------------------
// mlptw_table_ram
// Single-port table memory, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mlptw_table_ram
  import mlptw_pkg::*;
(
  input  wire logic clk,
  input  wire tbl_req_t req,
  output tbl_entry_t rd_data
);

  tbl_entry_t mem [STORE_DEPTH];
  tbl_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    rd_data_r <= mem[req.addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== hdl/mlptw_walk_ctrl.sv =====
// ----------------------------------------------------------------------------
// mlptw_walk_ctrl
// Walk sequencer: table clearing, per-level read/check/allocate, result reg.
// ----------------------------------------------------------------------------
`default_nettype none

module mlptw_walk_ctrl
  import mlptw_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  mlptw_in_if.sink    in_ch,
  mlptw_out_if.source out_ch,
  output tbl_req_t    req,
  input  wire tbl_entry_t rd_data
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_LOOK  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]          state_r, state_nxt;
  tbl_addr_t           clr_cnt_r, clr_cnt_nxt;
  logic                root_r, root_nxt;
  logic [NFREE_W-1:0]  nfree_r, nfree_nxt;
  logic                op_r, op_nxt;
  logic [VPN_W-1:0]    vpn_r, vpn_nxt;
  logic [PAGE_BITS-1:0] off_r, off_nxt;
  frame_t              base_r, base_nxt;
  logic [LVL_W-1:0]    lvl_r, lvl_nxt;
  logic [PA_W-1:0]     res_phys_r, res_phys_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [PA_W-1:0]     out_phys_r, out_phys_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;

  logic      pool_empty;
  logic      last_lvl;
  tbl_addr_t walk_addr;
  frame_t    new_frame;
  frame_t    hit_frame;

  assign pool_empty = (nfree_r >= NFREE_W'(FRAME_POOL));
  assign last_lvl   = (lvl_r == LVL_W'(LEVELS - 1));
  assign walk_addr  = {base_r, vpn_r[VPN_W-1 -: IDX_BITS]};
  assign new_frame  = nfree_r[FRAME_W-1:0];

  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    root_nxt       = root_r;
    nfree_nxt      = nfree_r;
    op_nxt         = op_r;
    vpn_nxt        = vpn_r;
    off_nxt        = off_r;
    base_nxt       = base_r;
    lvl_nxt        = lvl_r;
    res_phys_nxt   = res_phys_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r;
    out_phys_nxt   = out_phys_r;
    out_status_nxt = out_status_r;
    hit_frame      = rd_data.frame;
    req.we         = 1'b0;
    req.addr       = walk_addr;
    req.wdata      = '0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        req.we      = 1'b1;
        req.addr    = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + ADDR_W'(1);
        if (clr_cnt_r == ADDR_W'(STORE_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_ch.valid) begin
          op_nxt   = in_ch.operation;
          vpn_nxt  = VPN_W'(in_ch.virt_addr >> PAGE_BITS);
          off_nxt  = in_ch.virt_addr[PAGE_BITS-1:0];
          base_nxt = '0;
          lvl_nxt  = '0;
          res_phys_nxt = '0;
          state_nxt    = S_READ;
          if (!root_r) begin
            if (in_ch.operation == OP_TRANSLATE) begin
              res_status_nxt = ST_UNMAPPED;
              state_nxt      = S_DONE;
            end else if (pool_empty) begin
              res_status_nxt = ST_POOL_EMPTY;
              state_nxt      = S_DONE;
            end else begin
              // root table is the first frame taken
              root_nxt  = 1'b1;
              base_nxt  = new_frame;
              nfree_nxt = nfree_r + NFREE_W'(1);
            end
          end
        end
      end
      S_READ: begin
        state_nxt = S_LOOK;
      end
      S_LOOK: begin
        state_nxt = S_READ;
        if (!rd_data.valid) begin
          if (op_r == OP_TRANSLATE) begin
            res_status_nxt = ST_UNMAPPED;
            res_phys_nxt   = '0;
            state_nxt      = S_DONE;
          end else if (pool_empty) begin
            res_status_nxt = ST_POOL_EMPTY;
            res_phys_nxt   = '0;
            state_nxt      = S_DONE;
          end else begin
            req.we          = 1'b1;
            req.wdata.frame = new_frame;
            req.wdata.valid = 1'b1;
            hit_frame       = new_frame;
            nfree_nxt       = nfree_r + NFREE_W'(1);
          end
        end
        if (state_nxt == S_READ) begin
          base_nxt = hit_frame;
          lvl_nxt  = lvl_r + LVL_W'(1);
          vpn_nxt  = vpn_r << IDX_BITS;
          if (last_lvl) begin
            res_status_nxt = ST_OK;
            res_phys_nxt   = PA_W'({hit_frame, off_r});
            state_nxt      = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_phys_nxt   = res_phys_r;
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      root_r      <= 1'b0;
      nfree_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      root_r      <= root_nxt;
      nfree_r     <= nfree_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    vpn_r        <= vpn_nxt;
    off_r        <= off_nxt;
    base_r       <= base_nxt;
    lvl_r        <= lvl_nxt;
    res_phys_r   <= res_phys_nxt;
    res_status_r <= res_status_nxt;
    out_phys_r   <= out_phys_nxt;
    out_status_r <= out_status_nxt;
  end

  assign in_ch.ready      = (state_r == S_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.phys_addr = out_phys_r;
  assign out_ch.status    = out_status_r;

endmodule

`default_nettype wire

// ===== hdl/multi_level_page_table_walker.sv =====
// ----------------------------------------------------------------------------
// multi_level_page_table_walker
// Multi-level page table walk with translate and allocate, built-in frame pool.
// ----------------------------------------------------------------------------
// After reset the block sweeps all FRAME_POOL << (PAGE_BITS-3) table entries
// (32768 at the default settings) to zero, one entry per cycle, and holds
// in_ch.ready low until the sweep is done. It then handles one item at a
// time: it takes the item, then for each table level reads the memory and then
// checks the entry and, for allocate, writes the new entry, and last moves the
// result into the output register. A walk stops early on a missing entry.
// A pending result does not block the next walk; it only has to be taken
// before that walk finishes.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_level_page_table_walker
  import mlptw_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  mlptw_in_if.sink    in_ch,
  mlptw_out_if.source out_ch
);

  tbl_req_t   tbl_req;
  tbl_entry_t tbl_rd_data;

  mlptw_walk_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .req     (tbl_req),
    .rd_data (tbl_rd_data)
  );

  mlptw_table_ram u_ram (
    .clk     (clk),
    .req     (tbl_req),
    .rd_data (tbl_rd_data)
  );

endmodule

`default_nettype wire

// ===== hdl/mlptw_checker.sv =====
// ----------------------------------------------------------------------------
// mlptw_checker
// Port-level checks for the page table walker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mlptw_checker
  import mlptw_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire logic [PA_W-1:0]     out_phys_addr,
  input wire logic [STATUS_W-1:0] out_status
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_phys_addr) && $stable(out_status))
    else $error("result dropped or changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_UNMAPPED ||
                   out_status == ST_POOL_EMPTY))
    else $error("undefined status code");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_phys_addr == '0)
    else $error("nonzero address on failed item");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("new item taken while walk in progress");

  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result appeared without a walk");

endmodule

bind multi_level_page_table_walker mlptw_checker u_mlptw_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_phys_addr (out_ch.phys_addr),
  .out_status    (out_ch.status)
);

`default_nettype wire
